FILE: rtl/core/iidr_pkg.sv
// Shared types and constants for the IPv4 header ID rewriter.
package iidr_pkg;

    localparam int MAX_HDR_WORDS = 30;
    localparam int WORD_IDX_W    = $clog2(MAX_HDR_WORDS);

    localparam logic [WORD_IDX_W-1:0] ID_WORD_POS   = WORD_IDX_W'(2);
    localparam logic [WORD_IDX_W-1:0] CSUM_WORD_POS = WORD_IDX_W'(5);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_POS = WORD_IDX_W'(MAX_HDR_WORDS - 1);

    localparam logic [1:0] CFG_CAPTURE_MASK = 2'd0;
    localparam logic [1:0] CFG_RANDOM_MASK  = 2'd1;
    localparam logic [1:0] CFG_ID_SEED      = 2'd2;

    localparam logic [31:0] CAPTURE_MASK_RST = 32'h0000_0010;
    localparam logic [31:0] RANDOM_MASK_RST  = 32'h0000_0020;

    typedef enum logic [1:0] {
        ACT_NOT_CAPTURED = 2'd0,
        ACT_NOT_WRITABLE = 2'd1,
        ACT_SEQUENTIAL   = 2'd2,
        ACT_RANDOM       = 2'd3
    } action_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic        last_word;
        logic [31:0] packet_mark;
        logic        can_write;
        logic [15:0] random_id;
    } word_t;

    typedef struct packed {
        logic [31:0] capture_mask;
        logic [31:0] random_mask;
        logic        seed_load;
        logic [15:0] seed_value;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] new_id;
        logic [15:0] new_checksum;
    } result_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

FILE: rtl/core/iidr_cfg_regs.sv
// Configuration registers: capture mask, random mask and ID seed load.
module iidr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output iidr_pkg::cfg_t      cfg
);

    logic [31:0] capture_mask_reg;
    logic [31:0] random_mask_reg;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_mask_reg <= iidr_pkg::CAPTURE_MASK_RST;
            random_mask_reg  <= iidr_pkg::RANDOM_MASK_RST;
        end
        else if (wr)
        begin
            case (cfg_index)
                iidr_pkg::CFG_CAPTURE_MASK: capture_mask_reg <= cfg_data;
                iidr_pkg::CFG_RANDOM_MASK:  random_mask_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.capture_mask = capture_mask_reg;
    assign cfg.random_mask  = random_mask_reg;
    assign cfg.seed_load    = wr && (cfg_index == iidr_pkg::CFG_ID_SEED);
    assign cfg.seed_value   = cfg_data[15:0];

endmodule

FILE: rtl/core/iidr_in_stage.sv
// Input register stage for header words.
module iidr_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iidr_pkg::word_t     in_word,
    output logic                word_valid,
    output iidr_pkg::word_t     word,
    input  logic                word_take
);

    logic            valid_reg;
    iidr_pkg::word_t word_reg;
    logic            load;

    assign in_ready = !valid_reg || word_take;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (word_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

FILE: rtl/core/iidr_hdr_proc.sv
// Per-packet decision, ID counter and running ones'-complement sum.
module iidr_hdr_proc (
    input  logic                clk,
    input  logic                rst_n,
    input  iidr_pkg::cfg_t      cfg,
    input  logic                word_valid,
    input  iidr_pkg::word_t     word,
    output logic                word_take,
    input  logic                out_room,
    output logic                res_load,
    output iidr_pkg::result_t   res
);

    logic [iidr_pkg::WORD_IDX_W-1:0] idx_reg;
    logic [iidr_pkg::WORD_IDX_W-1:0] idx_next;
    logic [15:0]                     sum_reg;
    logic [15:0]                     sum_next;
    iidr_pkg::action_t               act_reg;
    iidr_pkg::action_t               act_next;
    logic [15:0]                     chosen_reg;
    logic [15:0]                     chosen_next;
    logic [15:0]                     counter_reg;
    logic [15:0]                     counter_next;

    logic        first;
    logic        done;
    logic        rewritten;
    logic [15:0] sum_base;
    logic [15:0] term;

    always_comb
    begin
        first       = (idx_reg == '0);
        act_next    = act_reg;
        chosen_next = chosen_reg;
        sum_base    = sum_reg;
        if (first)
        begin
            sum_base    = 16'd0;
            chosen_next = 16'd0;
            if ((word.packet_mark & cfg.capture_mask) == 32'd0)
            begin
                act_next = iidr_pkg::ACT_NOT_CAPTURED;
            end
            else if (!word.can_write)
            begin
                act_next = iidr_pkg::ACT_NOT_WRITABLE;
            end
            else if ((word.packet_mark & cfg.random_mask) != 32'd0)
            begin
                act_next    = iidr_pkg::ACT_RANDOM;
                chosen_next = word.random_id;
            end
            else
            begin
                act_next    = iidr_pkg::ACT_SEQUENTIAL;
                chosen_next = counter_reg;
            end
        end

        if (idx_reg == iidr_pkg::ID_WORD_POS)
        begin
            term = chosen_next;
        end
        else if (idx_reg == iidr_pkg::CSUM_WORD_POS)
        begin
            term = 16'd0;
        end
        else
        begin
            term = word.header_word;
        end
        sum_next = iidr_pkg::ones_add(sum_base, term);

        done      = word.last_word || (idx_reg >= iidr_pkg::LAST_WORD_POS);
        idx_next  = done ? '0 : idx_reg + 1'b1;
        word_take = word_valid && (!done || out_room);
        res_load  = word_take && done;

        rewritten        = (act_next == iidr_pkg::ACT_SEQUENTIAL)
                        || (act_next == iidr_pkg::ACT_RANDOM);
        res.action       = act_next;
        res.new_id       = rewritten ? chosen_next : 16'd0;
        res.new_checksum = rewritten ? ~sum_next : 16'd0;

        counter_next = counter_reg;
        if (cfg.seed_load)
        begin
            counter_next = cfg.seed_value;
        end
        else if (word_take && first && (act_next == iidr_pkg::ACT_SEQUENTIAL))
        begin
            counter_next = counter_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= 16'd0;
            act_reg     <= iidr_pkg::ACT_NOT_CAPTURED;
            chosen_reg  <= 16'd0;
            counter_reg <= 16'd0;
        end
        else
        begin
            counter_reg <= counter_next;
            if (word_take)
            begin
                idx_reg    <= idx_next;
                sum_reg    <= sum_next;
                act_reg    <= act_next;
                chosen_reg <= chosen_next;
            end
        end
    end

endmodule

FILE: rtl/core/iidr_out_stage.sv
// Result register stage.
module iidr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_load,
    input  iidr_pkg::result_t   res,
    output logic                out_room,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          action,
    output logic [15:0]         new_id,
    output logic [15:0]         new_checksum
);

    logic              valid_reg;
    iidr_pkg::result_t res_reg;

    assign out_room = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign action       = res_reg.action;
    assign new_id       = res_reg.new_id;
    assign new_checksum = res_reg.new_checksum;

endmodule

FILE: rtl/core/ipv4_id_rewriter.sv
// Top level of the IPv4 header ID rewriter with checksum recompute.
// Throughput: one header word per cycle, with no gap between packets, while the
// result register has room. A packet's last word passes the input register,
// then the result register after one ones'-complement add; a full one stalls it.
// Reset: rst_n clears the ID counter, the word position, the stage valids and
// sets the masks to their defaults; the block takes words from the first cycle.
module ipv4_id_rewriter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] header_word,
    input  logic        last_word,
    input  logic [31:0] packet_mark,
    input  logic        can_write,
    input  logic [15:0] random_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [15:0] new_id,
    output logic [15:0] new_checksum,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    iidr_pkg::cfg_t    cfg;
    iidr_pkg::word_t   in_word;
    iidr_pkg::word_t   word;
    iidr_pkg::result_t res;
    logic              word_valid;
    logic              word_take;
    logic              out_room;
    logic              res_load;

    assign in_word.header_word = header_word;
    assign in_word.last_word   = last_word;
    assign in_word.packet_mark = packet_mark;
    assign in_word.can_write   = can_write;
    assign in_word.random_id   = random_id;

    iidr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iidr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take)
    );

    iidr_hdr_proc u_proc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take),
        .out_room   (out_room),
        .res_load   (res_load),
        .res        (res)
    );

    iidr_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res          (res),
        .out_room     (out_room),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .new_id       (new_id),
        .new_checksum (new_checksum)
    );

endmodule
